// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the heart-rate peak detector.
// Synthesis builds define SYNTH, and the macros then expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/hrpd_pkg.sv =====
// Package for the heart-rate peak detector: widths, reset values and the
// divider request and response types. Depends on nothing.
`timescale 1ns / 1ps
package hrpd_pkg;
    localparam int SAMPLE_W     = 16;
    localparam int TIME_W       = 32;
    localparam int RATE_W       = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_ADDR_W   = 2;
    localparam int DIV_W        = 24;
    localparam int DVS_W        = 16;
    localparam int SAMPLE_TAPS_DEF = 5;
    localparam int RATE_TAPS_DEF   = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_PEAK_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_INTERVAL   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_INTERVAL   = 2'd2;

    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd20000;
    localparam logic [CFG_W-1:0] MIN_INT_RESET   = 16'd300;
    localparam logic [CFG_W-1:0] MAX_INT_RESET   = 16'd2000;

    // 60000 beats per minute-milliseconds, scaled by 256 for Q8.8.
    localparam logic [DIV_W-1:0] RATE_NUMERATOR = 24'd15360000;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;
endpackage

// ===== hw/rtl/hrpd_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on hrpd_pkg for widths and the request and response types.
`timescale 1ns / 1ps
module hrpd_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hrpd_pkg::t_div_req i_req,
    output hrpd_pkg::t_div_rsp o_rsp
);
    localparam int DIV_W = hrpd_pkg::DIV_W;
    localparam int DVS_W = hrpd_pkg::DVS_W;
    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_div;
    logic             r_done;
    logic [DVS_W:0]   n_trial;
    logic             n_ge;
    logic [DVS_W:0]   n_diff;

    always_comb begin
        n_trial = {r_rem, r_quo[DIV_W-1]};
        n_ge    = n_trial >= {1'b0, r_div};
        n_diff  = n_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[DVS_W-1:0] : n_trial[DVS_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], n_ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// ===== hw/rtl/heart_rate_peak_detector.sv =====
// Top level of the heart-rate peak detector: sample smoothing, peak tracking
// and beat-rate averaging around one shared serial divider.
// Depends on hrpd_pkg, hrpd_divider and assert_macros.svh.
//
// Usage: each input beat on the s_ channel carries one infrared sample and
// its millisecond timestamp. Every input beat produces exactly one output
// beat on the m_ channel with the rate flag in m_tuser and the raw rate,
// smoothed rate and filtered sample in m_tdata. Registers are written
// through i_cfg_we, i_cfg_addr and i_cfg_wdata while the block is idle;
// the user must keep to this, as the block itself does not enforce it. The
// block takes no new sample until the result of the last one has gone to the
// output register; s_tready rises together with m_tvalid. The shared serial
// divider sets the pace: it computes one quotient (load, shift-subtract steps,
// done) for the moving average and two more for a counted beat.
// Reset clears both history rings, the peak state and the last-peak timestamp,
// and loads the registers with their default values; no clearing pass is needed.
// When the receiver stalls, the finished result waits in the output
// register and a further sample is still taken; the block then holds its
// next result until the output register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module heart_rate_peak_detector #(
    parameter int SAMPLE_TAPS = hrpd_pkg::SAMPLE_TAPS_DEF,
    parameter int RATE_TAPS   = hrpd_pkg::RATE_TAPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: sample[15:0], time_ms[47:16].
    input  logic [47:0]                    s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: raw_rate[15:0], smoothed_rate[31:16],
    // filtered_sample[47:32].
    output logic [47:0]                    m_tdata,
    // Fields from bit 0: beat_valid[0].
    output logic                           m_tuser,
    input  logic                           i_cfg_we,
    input  logic [hrpd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [hrpd_pkg::CFG_W-1:0]      i_cfg_wdata
);
    localparam int SW     = hrpd_pkg::SAMPLE_W;
    localparam int TW     = hrpd_pkg::TIME_W;
    localparam int RW     = hrpd_pkg::RATE_W;
    localparam int DIV_W  = hrpd_pkg::DIV_W;
    localparam int DVS_W  = hrpd_pkg::DVS_W;
    localparam int SPOS_W = (SAMPLE_TAPS > 1) ? $clog2(SAMPLE_TAPS) : 1;
    localparam int RPOS_W = (RATE_TAPS > 1) ? $clog2(RATE_TAPS) : 1;
    localparam int SSUM_W = SW + $clog2(SAMPLE_TAPS);
    localparam int RSUM_W = RW + $clog2(RATE_TAPS);
    localparam int RCNT_W = $clog2(RATE_TAPS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_FILT, S_DET, S_CHK, S_RATE, S_SMST, S_SMOOTH, S_DONE
    } t_state;

    t_state                    r_state;
    logic [hrpd_pkg::CFG_W-1:0] r_threshold;
    logic [hrpd_pkg::CFG_W-1:0] r_min_int;
    logic [hrpd_pkg::CFG_W-1:0] r_max_int;
    logic [SW-1:0]             r_sring [SAMPLE_TAPS];
    logic [SPOS_W-1:0]         r_spos;
    logic [SSUM_W-1:0]         r_ssum;
    logic [RW-1:0]             r_rring [RATE_TAPS];
    logic [RPOS_W-1:0]         r_rpos;
    logic [RSUM_W-1:0]         r_rsum;
    logic [RCNT_W-1:0]         r_rcnt;
    logic [SW-1:0]             r_prev;
    logic                      r_in_peak;
    logic [TW-1:0]             r_last_peak;
    logic [TW-1:0]             r_time;
    logic [TW-1:0]             r_interval;
    logic                      r_beat_start;
    logic [SW-1:0]             r_filt;
    logic                      r_beat;
    logic [RW-1:0]             r_raw;
    logic [RW-1:0]             r_smooth;
    logic                      r_out_valid;
    logic                      r_out_beat;
    logic [47:0]               r_out_data;
    hrpd_pkg::t_div_req        r_div_req;
    hrpd_pkg::t_div_rsp        w_div_rsp;

    logic [SW-1:0]     n_sample;
    logic [SW-1:0]     n_sold;
    logic [SSUM_W-1:0] n_ssum;
    logic [RW-1:0]     n_rold;
    logic [RW-1:0]     n_raw;
    logic              n_start;
    logic              n_in_range;

    hrpd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        n_sample   = s_tdata[SW-1:0];
        n_sold     = r_sring[r_spos];
        n_ssum     = r_ssum - SSUM_W'(n_sold) + SSUM_W'(n_sample);
        n_rold     = r_rring[r_rpos];
        n_raw      = (|w_div_rsp.quotient[DIV_W-1:RW]) ? {RW{1'b1}}
                                                        : w_div_rsp.quotient[RW-1:0];
        n_start    = (r_filt > r_prev) && !r_in_peak && (r_filt > r_threshold);
        n_in_range = (r_interval > TW'(r_min_int)) && (r_interval < TW'(r_max_int));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_threshold <= hrpd_pkg::THRESHOLD_RESET;
            r_min_int   <= hrpd_pkg::MIN_INT_RESET;
            r_max_int   <= hrpd_pkg::MAX_INT_RESET;
            for (int i = 0; i < SAMPLE_TAPS; i++) begin
                r_sring[i] <= '0;
            end
            for (int i = 0; i < RATE_TAPS; i++) begin
                r_rring[i] <= '0;
            end
            r_spos          <= '0;
            r_ssum          <= '0;
            r_rpos          <= '0;
            r_rsum          <= '0;
            r_rcnt          <= '0;
            r_prev          <= '0;
            r_in_peak       <= 1'b0;
            r_last_peak     <= '0;
            r_smooth        <= '0;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    hrpd_pkg::REG_PEAK_THRESHOLD: r_threshold <= i_cfg_wdata;
                    hrpd_pkg::REG_MIN_INTERVAL:   r_min_int   <= i_cfg_wdata;
                    hrpd_pkg::REG_MAX_INTERVAL:   r_max_int   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_out_valid && m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_sring[r_spos]    <= n_sample;
                        r_spos             <= (r_spos == SPOS_W'(SAMPLE_TAPS - 1))
                                              ? '0 : r_spos + SPOS_W'(1);
                        r_ssum             <= n_ssum;
                        r_time             <= s_tdata[SW +: TW];
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= DIV_W'(n_ssum);
                        r_div_req.divisor  <= DVS_W'(SAMPLE_TAPS);
                        r_state            <= S_FILT;
                    end
                end
                S_FILT: begin
                    if (w_div_rsp.done) begin
                        r_filt  <= w_div_rsp.quotient[SW-1:0];
                        r_state <= S_DET;
                    end
                end
                S_DET: begin
                    r_beat_start <= n_start;
                    r_interval   <= r_time - r_last_peak;
                    if (n_start) begin
                        r_in_peak   <= 1'b1;
                        r_last_peak <= r_time;
                    end else if (r_filt < r_prev) begin
                        r_in_peak <= 1'b0;
                    end
                    r_prev  <= r_filt;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_raw <= '0;
                    if (r_beat_start && n_in_range) begin
                        r_beat             <= 1'b1;
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= hrpd_pkg::RATE_NUMERATOR;
                        r_div_req.divisor  <= r_interval[DVS_W-1:0];
                        r_state            <= S_RATE;
                    end else begin
                        r_beat  <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_RATE: begin
                    if (w_div_rsp.done) begin
                        r_raw           <= n_raw;
                        r_rring[r_rpos] <= n_raw;
                        r_rpos          <= (r_rpos == RPOS_W'(RATE_TAPS - 1))
                                           ? '0 : r_rpos + RPOS_W'(1);
                        r_rsum          <= r_rsum - RSUM_W'(n_rold) + RSUM_W'(n_raw);
                        r_rcnt          <= r_rcnt + RCNT_W'(1)
                                           - RCNT_W'(n_rold != '0);
                        r_state         <= S_SMST;
                    end
                end
                S_SMST: begin
                    r_div_req.start    <= 1'b1;
                    r_div_req.dividend <= DIV_W'(r_rsum);
                    r_div_req.divisor  <= DVS_W'(r_rcnt);
                    r_state            <= S_SMOOTH;
                end
                S_SMOOTH: begin
                    if (w_div_rsp.done) begin
                        r_smooth <= w_div_rsp.quotient[RW-1:0];
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_beat  <= r_beat;
                        r_out_data  <= {r_filt, r_smooth, r_raw};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = i_rst_n && (r_state == S_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_beat;

    `ASSERT_IMPLY(a_done_in_wait, i_clk, i_rst_n, w_div_rsp.done,
        r_state == S_FILT || r_state == S_RATE || r_state == S_SMOOTH)
    `ASSERT_IMPLY(a_no_beat_zero_rate, i_clk, i_rst_n, m_tvalid && !m_tuser,
        m_tdata[15:0] == 16'd0)
    `ASSERT_IMPLY(a_beat_rates_set, i_clk, i_rst_n, m_tvalid && m_tuser,
        m_tdata[15:0] != 16'd0 && m_tdata[31:16] != 16'd0)
    `ASSERT_PROP(a_rate_count_bound, i_clk, i_rst_n, r_rcnt <= RCNT_W'(RATE_TAPS))
endmodule
